### src/rlds_pkg.sv
`default_nettype none
package rlds_pkg;

  localparam int MAX_LINES = 1024;
  localparam int MAX_RUNS  = 4096;
  localparam int LINE_AW   = $clog2(MAX_LINES);
  localparam int RUN_AW    = $clog2(MAX_RUNS);

  localparam logic [2:0] CMD_LOAD_LINE = 3'd0;
  localparam logic [2:0] CMD_LOAD_RUN  = 3'd1;
  localparam logic [2:0] CMD_RASTER    = 3'd2;
  localparam logic [2:0] CMD_LINE_SCAN = 3'd3;
  localparam logic [2:0] CMD_NEXT_RUN  = 3'd4;
  localparam logic [2:0] CMD_NEXT_LINE = 3'd5;

  localparam logic [2:0] REG_SCAN_DIRECTION = 3'd0;
  localparam logic [2:0] REG_DOMAIN_KIND    = 3'd1;
  localparam logic [2:0] REG_FIRST_LINE     = 3'd2;
  localparam logic [2:0] REG_LAST_LINE      = 3'd3;
  localparam logic [2:0] REG_FIRST_COLUMN   = 3'd4;
  localparam logic [2:0] REG_LAST_COLUMN    = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_END   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_NORUN = 2'd3;

  localparam logic [1:0] KIND_LIST = 2'd0;
  localparam logic [1:0] KIND_RECT = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    OP_LOAD_LINE, OP_LOAD_RUN, OP_RASTER, OP_LINE_SCAN, OP_NEXT_RUN, OP_NEXT_LINE, OP_NOP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [12:0]        run_count;
    logic [14:0]        left_offset;
    logic [14:0]        right_offset;
    logic signed [15:0] start_line;
    logic [10:0]        line_step;
  } entry_t;

  typedef struct packed {
    logic [1:0]         scan_direction;
    logic [1:0]         domain_kind;
    logic signed [15:0] first_line;
    logic signed [15:0] last_line;
    logic signed [15:0] first_column;
    logic signed [15:0] last_column;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] line_position;
    logic signed [15:0] left_column;
    logic signed [15:0] right_column;
    logic [16:0]        column_count;
    logic [10:0]        lines_advanced;
  } res_t;

endpackage
`default_nettype wire

### src/rlds_if.sv
`default_nettype none
interface rlds_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic [12:0]        run_count;
  logic [14:0]        left_offset;
  logic [14:0]        right_offset;
  logic signed [15:0] start_line;
  logic [10:0]        line_step;
  modport source(output valid, command, run_count, left_offset, right_offset, start_line,
                 line_step, input ready);
  modport sink(input valid, command, run_count, left_offset, right_offset, start_line,
               line_step, output ready);
endinterface

interface rlds_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [15:0] line_position;
  logic signed [15:0] left_column;
  logic signed [15:0] right_column;
  logic [16:0]        column_count;
  logic [10:0]        lines_advanced;
  modport source(output valid, status, line_position, left_column, right_column,
                 column_count, lines_advanced, input ready);
  modport sink(input valid, status, line_position, left_column, right_column,
               column_count, lines_advanced, output ready);
endinterface
`default_nettype wire

### src/rlds_front.sv
`default_nettype none
module rlds_front (
  input  wire logic       clk,
  input  wire logic       rst,
  rlds_in_if.sink         item,
  output rlds_pkg::entry_t head,
  output logic            head_valid,
  input  wire logic       pop
);
  import rlds_pkg::*;

  entry_t     slots [2];
  entry_t     incoming;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       take;

  always_comb begin
    incoming.run_count    = item.run_count;
    incoming.left_offset  = item.left_offset;
    incoming.right_offset = item.right_offset;
    incoming.start_line   = item.start_line;
    incoming.line_step    = item.line_step;
    unique case (item.command)
      CMD_LOAD_LINE: incoming.op = OP_LOAD_LINE;
      CMD_LOAD_RUN:  incoming.op = OP_LOAD_RUN;
      CMD_RASTER:    incoming.op = OP_RASTER;
      CMD_LINE_SCAN: incoming.op = OP_LINE_SCAN;
      CMD_NEXT_RUN:  incoming.op = OP_NEXT_RUN;
      CMD_NEXT_LINE: incoming.op = OP_NEXT_LINE;
      default:       incoming.op = OP_NOP;
    endcase
  end

  assign item.ready = (count != 2'd2);
  assign push       = item.valid && item.ready;
  assign head_valid = (count != 2'd0);
  assign take       = pop && head_valid;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (take) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, take};
    end
  end
endmodule
`default_nettype wire

### src/rlds_engine.sv
`default_nettype none
module rlds_engine (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire rlds_pkg::cfg_t   cfg,
  input  wire rlds_pkg::entry_t head,
  input  wire logic             head_valid,
  output logic                  pop,
  rlds_out_if.source            result
);
  import rlds_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE      = 4'b0001,
    S_LINE_STEP = 4'b0010,
    S_LINE_CHK  = 4'b0100,
    S_RUN_OUT   = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [LINE_AW:0]     load_line_ptr, load_line_ptr_next;
  logic [RUN_AW:0]      load_run_ptr, load_run_ptr_next;
  logic signed [15:0]   cur_line, cur_line_next;
  logic signed [17:0]   lines_left, lines_left_next;
  logic [RUN_AW-1:0]    run_idx, run_idx_next;
  logic [12:0]          runs_left, runs_left_next;
  logic [LINE_AW-1:0]   line_idx, line_idx_next;
  logic                 rect, rect_next;
  logic                 line_down, line_down_next;
  logic                 col_down, col_down_next;
  logic                 jump, jump_next;
  logic [10:0]          adv, adv_next;
  logic                 o_valid;
  res_t                 o_res, res_next;
  logic                 emit;

  logic                 lwe, rwe;
  logic [RUN_AW-1:0]    start_mem [MAX_LINES];
  logic [12:0]          cnt_mem   [MAX_LINES];
  logic [14:0]          left_mem  [MAX_RUNS];
  logic [14:0]          right_mem [MAX_RUNS];
  logic [RUN_AW-1:0]    rd_start;
  logic [12:0]          rd_cnt;
  logic [14:0]          rd_left, rd_right;

  logic signed [17:0]   fl, ll, sl, stp, diff, cl_step, left_after;
  logic [12:0]          cnt_less;

  function automatic logic signed [17:0] sx(input logic signed [15:0] v);
    return {{2{v[15]}}, v};
  endfunction

  function automatic res_t rect_res(input logic signed [15:0] line, input cfg_t c);
    res_t r;
    logic signed [17:0] n;
    n = sx(c.last_column) - sx(c.first_column) + 18'sd1;
    r.status         = ST_OK;
    r.line_position  = line;
    r.left_column    = c.first_column;
    r.right_column   = c.last_column;
    r.column_count   = n[17] ? 17'd0 : n[16:0];
    r.lines_advanced = 11'd1;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (lwe) begin
      start_mem[load_line_ptr[LINE_AW-1:0]] <= load_run_ptr[RUN_AW-1:0];
      cnt_mem[load_line_ptr[LINE_AW-1:0]]   <= head.run_count;
    end
    rd_start <= start_mem[line_idx_next];
    rd_cnt   <= cnt_mem[line_idx_next];
  end

  always_ff @(posedge clk) begin
    if (rwe) begin
      left_mem[load_run_ptr[RUN_AW-1:0]]  <= head.left_offset;
      right_mem[load_run_ptr[RUN_AW-1:0]] <= head.right_offset;
    end
    rd_left  <= left_mem[run_idx_next];
    rd_right <= right_mem[run_idx_next];
  end

  assign fl         = sx(cfg.first_line);
  assign ll         = sx(cfg.last_line);
  assign sl         = sx(head.start_line);
  assign stp        = {7'd0, head.line_step};
  assign diff       = ll - fl;
  assign cl_step    = line_down ? sx(cur_line) - stp : sx(cur_line) + stp;
  assign left_after = lines_left - stp;
  assign cnt_less   = rd_cnt - 13'd1;

  always_comb begin
    logic signed [17:0] lo_c, hi_c, cnt_c, li;
    state_next         = state;
    load_line_ptr_next = load_line_ptr;
    load_run_ptr_next  = load_run_ptr;
    cur_line_next      = cur_line;
    lines_left_next    = lines_left;
    run_idx_next       = run_idx;
    runs_left_next     = runs_left;
    line_idx_next      = line_idx;
    rect_next          = rect;
    line_down_next     = line_down;
    col_down_next      = col_down;
    jump_next          = jump;
    adv_next           = adv;
    res_next           = '0;
    emit               = 1'b0;
    lwe                = 1'b0;
    rwe                = 1'b0;
    pop                = 1'b0;
    lo_c               = {3'd0, rd_left};
    hi_c               = {3'd0, rd_right};
    cnt_c              = hi_c - lo_c + 18'sd1;
    li                 = '0;
    unique case (state)
      S_IDLE: begin
        if (head_valid && !o_valid) begin
          pop  = 1'b1;
          emit = 1'b1;
          unique case (head.op)
            OP_LOAD_LINE: begin
              if (load_line_ptr >= (LINE_AW + 1)'(MAX_LINES)) begin
                res_next.status = ST_FULL;
              end else begin
                lwe                = 1'b1;
                load_line_ptr_next = load_line_ptr + 1'b1;
              end
            end
            OP_LOAD_RUN: begin
              if (load_run_ptr >= (RUN_AW + 1)'(MAX_RUNS)) begin
                res_next.status = ST_FULL;
              end else begin
                rwe               = 1'b1;
                load_run_ptr_next = load_run_ptr + 1'b1;
              end
            end
            OP_RASTER, OP_LINE_SCAN: begin
              load_line_ptr_next = '0;
              load_run_ptr_next  = '0;
              runs_left_next     = '0;
              run_idx_next       = '0;
              rect_next          = (cfg.domain_kind == KIND_RECT);
              line_down_next     = cfg.scan_direction[1];
              col_down_next      = cfg.scan_direction[0];
              if (cfg.domain_kind[1]) begin
                lines_left_next = -18'sd1;
                cur_line_next   = '0;
                line_idx_next   = '0;
                line_down_next  = 1'b0;
                col_down_next   = 1'b0;
              end else if (head.op == OP_RASTER) begin
                lines_left_next = diff + 18'sd1;
                if (cfg.scan_direction[1]) begin
                  cur_line_next = cfg.last_line + 16'sd1;
                  li            = diff + 18'sd1;
                end else begin
                  cur_line_next = cfg.first_line - 16'sd1;
                  li            = -18'sd1;
                end
                line_idx_next = li[LINE_AW-1:0];
              end else begin
                if (cfg.scan_direction[1]) begin
                  li              = sl + stp;
                  lines_left_next = sl - fl + 18'sd1;
                  li              = li - fl;
                end else begin
                  li              = sl - stp;
                  lines_left_next = ll - sl + 18'sd1;
                  li              = li - fl;
                end
                cur_line_next = cfg.scan_direction[1] ? head.start_line + stp[15:0]
                                                      : head.start_line - stp[15:0];
                line_idx_next = li[LINE_AW-1:0];
              end
            end
            OP_NEXT_RUN: begin
              if (lines_left[17]) begin
                res_next.status = ST_END;
              end else if (rect) begin
                cur_line_next = line_down ? cur_line - 16'sd1 : cur_line + 16'sd1;
                if (lines_left == 18'sd0) begin
                  lines_left_next = -18'sd1;
                  res_next.status = ST_END;
                end else begin
                  lines_left_next = lines_left - 18'sd1;
                  res_next        = rect_res(cur_line_next, cfg);
                end
              end else if (runs_left != 13'd0) begin
                emit           = 1'b0;
                runs_left_next = runs_left - 13'd1;
                run_idx_next   = col_down ? run_idx - 1'b1 : run_idx + 1'b1;
                adv_next       = '0;
                state_next     = S_RUN_OUT;
              end else begin
                emit       = 1'b0;
                adv_next   = '0;
                jump_next  = 1'b0;
                state_next = S_LINE_STEP;
              end
            end
            OP_NEXT_LINE: begin
              if (lines_left[17]) begin
                res_next.status = ST_END;
              end else begin
                cur_line_next   = cl_step[15:0];
                lines_left_next = left_after;
                if (left_after[17]) begin
                  lines_left_next = -18'sd1;
                  res_next.status = ST_END;
                end else if (rect) begin
                  res_next = rect_res(cur_line_next, cfg);
                end else begin
                  emit          = 1'b0;
                  line_idx_next = line_down ? line_idx - stp[LINE_AW-1:0]
                                            : line_idx + stp[LINE_AW-1:0];
                  adv_next      = '0;
                  jump_next     = 1'b1;
                  state_next    = S_LINE_CHK;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LINE_STEP: begin
        cur_line_next = line_down ? cur_line - 16'sd1 : cur_line + 16'sd1;
        if (lines_left[17] || lines_left == 18'sd0) begin
          lines_left_next = -18'sd1;
          runs_left_next  = '0;
          res_next.status = ST_END;
          emit            = 1'b1;
          state_next      = S_IDLE;
        end else begin
          lines_left_next = lines_left - 18'sd1;
          line_idx_next   = line_down ? line_idx - 1'b1 : line_idx + 1'b1;
          if (adv != 11'h7FF) adv_next = adv + 11'd1;
          state_next = S_LINE_CHK;
        end
      end
      S_LINE_CHK: begin
        if (rd_cnt == 13'd0) begin
          if (jump) begin
            runs_left_next         = '0;
            res_next.status        = ST_NORUN;
            res_next.line_position = cur_line;
            emit                   = 1'b1;
            state_next             = S_IDLE;
          end else begin
            state_next = S_LINE_STEP;
          end
        end else begin
          runs_left_next = cnt_less;
          run_idx_next   = col_down ? rd_start + cnt_less[RUN_AW-1:0] : rd_start;
          state_next     = S_RUN_OUT;
        end
      end
      S_RUN_OUT: begin
        li                      = lo_c + sx(cfg.first_column);
        res_next.left_column    = li[15:0];
        li                      = hi_c + sx(cfg.first_column);
        res_next.right_column   = li[15:0];
        res_next.status         = ST_OK;
        res_next.line_position  = cur_line;
        res_next.column_count   = cnt_c[17] ? 17'd0 : cnt_c[16:0];
        res_next.lines_advanced = adv;
        emit                    = 1'b1;
        state_next              = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      load_line_ptr <= '0;
      load_run_ptr  <= '0;
      cur_line      <= '0;
      lines_left    <= -18'sd1;
      run_idx       <= '0;
      runs_left     <= '0;
      line_idx      <= '0;
      rect          <= 1'b0;
      line_down     <= 1'b0;
      col_down      <= 1'b0;
      jump          <= 1'b0;
      adv           <= '0;
      o_valid       <= 1'b0;
    end else begin
      state         <= state_next;
      load_line_ptr <= load_line_ptr_next;
      load_run_ptr  <= load_run_ptr_next;
      cur_line      <= cur_line_next;
      lines_left    <= lines_left_next;
      run_idx       <= run_idx_next;
      runs_left     <= runs_left_next;
      line_idx      <= line_idx_next;
      rect          <= rect_next;
      line_down     <= line_down_next;
      col_down      <= col_down_next;
      jump          <= jump_next;
      adv           <= adv_next;
      o_valid       <= emit || (o_valid && !result.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) o_res <= res_next;
  end

  assign result.valid          = o_valid;
  assign result.status         = o_res.status;
  assign result.line_position  = o_res.line_position;
  assign result.left_column    = o_res.left_column;
  assign result.right_column   = o_res.right_column;
  assign result.column_count   = o_res.column_count;
  assign result.lines_advanced = o_res.lines_advanced;
endmodule
`default_nettype wire

### src/run_length_domain_scanner.sv
// Commands pass a two-entry queue, then a sequencer; one result per command.
// Loads, scan starts, unused commands, rectangle steps end in the idle state.
// Next runs go to run output, next lines via line check, new lines via line
// step. No command is taken while the output register still holds a result.
// Synchronous reset clears pointers, scan state and registers; the line and run
// memories are not cleared and hold nothing defined until loaded.
`default_nettype none
module run_length_domain_scanner (
  input  wire logic        clk,
  input  wire logic        rst,
  rlds_in_if.sink          item,
  rlds_out_if.source       result,
  input  wire logic        write_enable,
  input  wire logic [2:0]  register_index,
  input  wire logic [15:0] write_data
);
  import rlds_pkg::*;

  cfg_t   cfg;
  entry_t head;
  logic   head_valid;
  logic   pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scan_direction <= '0;
      cfg.domain_kind    <= KIND_EMPTY;
      cfg.first_line     <= '0;
      cfg.last_line      <= '0;
      cfg.first_column   <= '0;
      cfg.last_column    <= '0;
    end else if (write_enable) begin
      unique case (register_index)
        REG_SCAN_DIRECTION: cfg.scan_direction <= write_data[1:0];
        REG_DOMAIN_KIND:    cfg.domain_kind    <= write_data[1:0];
        REG_FIRST_LINE:     cfg.first_line     <= write_data;
        REG_LAST_LINE:      cfg.last_line      <= write_data;
        REG_FIRST_COLUMN:   cfg.first_column   <= write_data;
        REG_LAST_COLUMN:    cfg.last_column    <= write_data;
        default: begin
        end
      endcase
    end
  end

  rlds_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  rlds_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .result     (result)
  );
endmodule
`default_nettype wire
